// ===== rtl/tem_pkg.sv =====
// ----------------------------------------------------------------------------
// Text extent package
// Shared widths, reset values, register indexes and the types that pass
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package tem_pkg;

  localparam int unsigned GLYPHS_DEFAULT      = 1024;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  localparam int unsigned LH_W    = 10;
  localparam int unsigned CODE_W  = 21;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned GCODE_W = 10;
  localparam int unsigned ADV_W   = 10;
  localparam int unsigned GW_W    = 10;
  localparam int unsigned TRIM_W  = 12;
  localparam int unsigned X_W     = 24;
  localparam int unsigned MAXX_W  = 23;
  localparam int unsigned H_W     = 24;
  localparam int unsigned CFGD_W  = 21;
  localparam int unsigned CFGI_W  = 2;

  localparam logic [LH_W-1:0]   LINE_HEIGHT_RESET   = 10'd16;
  localparam logic              ESCAPE_ENABLE_RESET = 1'b0;
  localparam logic [CODE_W-1:0] ESCAPE_CODE_RESET   = 21'd94;
  localparam logic              TRIM_LAST_RESET     = 1'b1;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [CODE_W-1:0] NEWLINE_CODE = 21'h0A;
  localparam logic [1:0]        ESCAPE_SKIP  = 2'd3;

  localparam logic [X_W-1:0] X_POS_LIMIT = 24'h7FFFFF;
  localparam logic [X_W-1:0] X_NEG_LIMIT = 24'h800000;
  localparam logic [H_W-1:0] H_LIMIT     = 24'hFFFFFF;

  typedef enum logic [CFGI_W-1:0] {
    REG_LINE_HEIGHT   = 2'd0,
    REG_ESCAPE_ENABLE = 2'd1,
    REG_ESCAPE_CODE   = 2'd2,
    REG_TRIM_LAST     = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [LH_W-1:0]   line_height;
    logic              escape_enable;
    logic [CODE_W-1:0] escape_code;
    logic              trim_last;
  } cfg_t;

  // Table entry; the trimmed extent (offset plus width) is formed at load time.
  typedef struct packed {
    logic              present;
    logic [ADV_W-1:0]  advance;
    logic [TRIM_W-1:0] trim;
  } glyph_t;

  typedef struct packed {
    logic              nl_byte;
    logic              last;
    logic              cp_newline;
    logic              glyph;
    logic [ADV_W-1:0]  advance;
    logic [TRIM_W-1:0] trim;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/tem_if.sv =====
// ----------------------------------------------------------------------------
// Text extent channel interfaces
// Valid/ready channels for input items and for measurement results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tem_item_if import tem_pkg::*;;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [BYTE_W-1:0]  text_byte;
  logic               last;
  logic [GCODE_W-1:0] glyph_code;
  logic               glyph_present;
  logic [ADV_W-1:0]   glyph_advance;
  logic [ADV_W-1:0]   glyph_xoffset;
  logic [GW_W-1:0]    glyph_width;

  modport source (
    output valid, kind, text_byte, last, glyph_code, glyph_present,
    output glyph_advance, glyph_xoffset, glyph_width,
    input  ready
  );
  modport sink (
    input  valid, kind, text_byte, last, glyph_code, glyph_present,
    input  glyph_advance, glyph_xoffset, glyph_width,
    output ready
  );
endinterface

interface tem_result_if import tem_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MAXX_W-1:0] text_width;
  logic [H_W-1:0]    text_height;
  logic              saturated;

  modport source (output valid, text_width, text_height, saturated, input ready);
  modport sink   (input valid, text_width, text_height, saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/text_extent_measure.sv =====
// ----------------------------------------------------------------------------
// Text extent measure
// Measures the pixel width and height of a UTF-8 string set in a bitmap font
// held in a glyph table that is loaded through the same item channel.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle unless the queue is full; the last byte
// of a string holds the back end while the final glyph is added and registered.
// Path: each byte passes the front-end stage and the queue; the result is registered.
// Reset: after rst falls, items are refused for GLYPHS cycles while the glyph
// table is swept clear; configuration writes are taken throughout.
`default_nettype none

module text_extent_measure import tem_pkg::*; #(
  parameter int unsigned GLYPHS      = GLYPHS_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  tem_item_if.sink               items,
  tem_result_if.source           results,
  input  wire logic              cfg_we,
  input  wire logic [CFGI_W-1:0] cfg_index,
  input  wire logic [CFGD_W-1:0] cfg_data
);

  cfg_t cfg;
  logic op_valid, op_ready;
  op_t  op;
  logic q_valid, q_ready;
  op_t  q_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_height   <= LINE_HEIGHT_RESET;
      cfg.escape_enable <= ESCAPE_ENABLE_RESET;
      cfg.escape_code   <= ESCAPE_CODE_RESET;
      cfg.trim_last     <= TRIM_LAST_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_LINE_HEIGHT:   cfg.line_height   <= cfg_data[LH_W-1:0];
        REG_ESCAPE_ENABLE: cfg.escape_enable <= cfg_data[0];
        REG_ESCAPE_CODE:   cfg.escape_code   <= cfg_data[CODE_W-1:0];
        REG_TRIM_LAST:     cfg.trim_last     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tem_front #(.GLYPHS(GLYPHS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .cfg      (cfg),
    .op_valid (op_valid),
    .op       (op),
    .op_ready (op_ready)
  );

  tem_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (op_valid),
    .push_op    (op),
    .push_ready (op_ready),
    .pop_valid  (q_valid),
    .pop_op     (q_op),
    .pop_ready  (q_ready)
  );

  tem_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op_valid (q_valid),
    .op       (q_op),
    .op_ready (q_ready),
    .results  (results)
  );

endmodule

`default_nettype wire

// ===== rtl/tem_front.sv =====
// ----------------------------------------------------------------------------
// Text extent front end
// Accepts transactions, holds the glyph table, decodes UTF-8 and escapes, and
// hands one classified operation per text byte to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tem_front import tem_pkg::*; #(
  parameter int unsigned GLYPHS = GLYPHS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tem_item_if.sink   items,
  input  wire cfg_t  cfg,
  output logic       op_valid,
  output op_t        op,
  input  wire logic  op_ready
);

  localparam int unsigned AW = $clog2(GLYPHS);

  glyph_t mem [GLYPHS];
  glyph_t rdata;
  glyph_t wdata;

  logic          clr;
  logic [AW-1:0] clr_idx;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic          wen;

  logic [CODE_W-1:0] acc, acc_next;
  logic [1:0]        bytes_left, bytes_left_next;
  logic [1:0]        skip_left, skip_left_next;

  logic s1_valid;
  logic s1_nl_byte, s1_last, s1_cp_newline, s1_lookup;

  logic              accept, text_acc, load_acc;
  logic              cp_done, cp_newline, lookup;
  logic [CODE_W-1:0] cp;
  logic [CODE_W-1:0] gcode;
  logic [BYTE_W-1:0] b;

  assign items.ready = !clr && (!s1_valid || op_ready);
  assign accept      = items.valid && items.ready;
  assign text_acc    = accept && !items.kind;
  assign load_acc    = accept && items.kind;
  assign b           = items.text_byte;
  assign gcode       = CODE_W'(items.glyph_code);

  always_comb begin
    acc_next        = acc;
    bytes_left_next = bytes_left;
    skip_left_next  = skip_left;
    cp_done         = 1'b0;
    cp              = acc;
    cp_newline      = 1'b0;
    lookup          = 1'b0;
    if (bytes_left != 2'd0) begin
      acc_next        = {acc[CODE_W-7:0], b[5:0]};
      bytes_left_next = bytes_left - 2'd1;
      cp_done         = (bytes_left == 2'd1);
      cp              = acc_next;
    end else if (!b[7]) begin
      cp_done = 1'b1;
      cp      = CODE_W'(b);
    end else if (b[7:5] == 3'b110) begin
      acc_next        = CODE_W'(b[4:0]);
      bytes_left_next = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      acc_next        = CODE_W'(b[3:0]);
      bytes_left_next = 2'd2;
    end else begin
      acc_next        = CODE_W'(b[2:0]);
      bytes_left_next = 2'd3;
    end
    if (cp_done) begin
      if (skip_left != 2'd0) begin
        skip_left_next = skip_left - 2'd1;
      end else if (cp == NEWLINE_CODE) begin
        cp_newline = 1'b1;
      end else if (cfg.escape_enable && (cp == cfg.escape_code)) begin
        skip_left_next = ESCAPE_SKIP;
      end else begin
        lookup = (32'(cp) < 32'(GLYPHS));
      end
    end
    if (items.last) begin
      acc_next        = '0;
      bytes_left_next = 2'd0;
      skip_left_next  = 2'd0;
    end
  end

  assign raddr = cp[AW-1:0];

  always_comb begin
    wdata.present = items.glyph_present;
    wdata.advance = items.glyph_advance;
    wdata.trim    = {{(TRIM_W-ADV_W){items.glyph_xoffset[ADV_W-1]}}, items.glyph_xoffset}
                  + TRIM_W'(items.glyph_width);
    waddr         = gcode[AW-1:0];
    wen           = load_acc && (32'(items.glyph_code) < 32'(GLYPHS));
    if (clr) begin
      wdata = '0;
      waddr = clr_idx;
      wen   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (text_acc) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr        <= 1'b1;
      clr_idx    <= '0;
      s1_valid   <= 1'b0;
      acc        <= '0;
      bytes_left <= 2'd0;
      skip_left  <= 2'd0;
    end else begin
      if (clr) begin
        if (clr_idx == AW'(GLYPHS - 1)) begin
          clr <= 1'b0;
        end
        clr_idx <= clr_idx + AW'(1);
      end
      if (accept) begin
        s1_valid <= !items.kind;
      end else if (op_ready) begin
        s1_valid <= 1'b0;
      end
      if (text_acc) begin
        acc        <= acc_next;
        bytes_left <= bytes_left_next;
        skip_left  <= skip_left_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_acc) begin
      s1_nl_byte    <= (b == NEWLINE_BYTE);
      s1_last       <= items.last;
      s1_cp_newline <= cp_newline;
      s1_lookup     <= lookup;
    end
  end

  assign op_valid = s1_valid;

  always_comb begin
    op.nl_byte    = s1_nl_byte;
    op.last       = s1_last;
    op.cp_newline = s1_cp_newline;
    op.glyph      = s1_lookup && rdata.present;
    op.advance    = rdata.advance;
    op.trim       = rdata.trim;
  end

endmodule

`default_nettype wire

// ===== rtl/tem_queue.sv =====
// ----------------------------------------------------------------------------
// Text extent operation queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tem_queue import tem_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  input  wire op_t  push_op,
  output logic      push_ready,
  output logic      pop_valid,
  output op_t       pop_op,
  input  wire logic pop_ready
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  op_t           slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          push, pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tem_back.sv =====
// ----------------------------------------------------------------------------
// Text extent back end
// Resolves pending glyphs, accumulates line width and height, and registers
// the result of each string.
// ----------------------------------------------------------------------------
`default_nettype none

module tem_back import tem_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  op_valid,
  input  wire op_t   op,
  output logic       op_ready,
  tem_result_if.source results
);

  logic              started, sat, pend_v, fin;
  logic [X_W-1:0]    cur_x;
  logic [MAXX_W-1:0] max_x;
  logic [H_W-1:0]    height;
  logic [ADV_W-1:0]  pend_adv;
  logic [TRIM_W-1:0] pend_trim;

  logic              pop, fire;
  logic [H_W-1:0]    h_base;
  logic [H_W:0]      h_sum;
  logic [TRIM_W-1:0] adv_ext, d1, d2;
  logic [X_W:0]      sum1, sum2;
  logic [X_W-1:0]    x1, x2;
  logic              ovf1, ovf2;

  function automatic logic [X_W-1:0] clamp_x(input logic [X_W:0] s);
    logic [X_W-1:0] r;
    r = s[X_W-1:0];
    if (s[X_W] != s[X_W-1]) begin
      r = s[X_W] ? X_NEG_LIMIT : X_POS_LIMIT;
    end
    return r;
  endfunction

  function automatic logic [MAXX_W-1:0] widest(input logic [MAXX_W-1:0] m,
                                               input logic [X_W-1:0] x);
    logic [MAXX_W-1:0] r;
    r = m;
    if (!x[X_W-1] && (x[MAXX_W-1:0] > m)) begin
      r = x[MAXX_W-1:0];
    end
    return r;
  endfunction

  assign op_ready = !fin;
  assign pop      = op_valid && !fin;
  assign fire     = fin && (!results.valid || results.ready);

  always_comb begin
    h_base  = started ? height : H_W'(cfg.line_height);
    h_sum   = {1'b0, h_base} + (H_W+1)'(cfg.line_height);
    adv_ext = {{(TRIM_W-ADV_W){pend_adv[ADV_W-1]}}, pend_adv};
    d1      = '0;
    if (pend_v) begin
      d1 = (cfg.trim_last && op.nl_byte) ? pend_trim : adv_ext;
    end
    d2 = '0;
    if (pend_v) begin
      d2 = cfg.trim_last ? pend_trim : adv_ext;
    end
    sum1 = {cur_x[X_W-1], cur_x} + {{(X_W+1-TRIM_W){d1[TRIM_W-1]}}, d1};
    sum2 = {cur_x[X_W-1], cur_x} + {{(X_W+1-TRIM_W){d2[TRIM_W-1]}}, d2};
    ovf1 = sum1[X_W] ^ sum1[X_W-1];
    ovf2 = sum2[X_W] ^ sum2[X_W-1];
    x1   = clamp_x(sum1);
    x2   = clamp_x(sum2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      sat           <= 1'b0;
      pend_v        <= 1'b0;
      fin           <= 1'b0;
      cur_x         <= '0;
      max_x         <= '0;
      height        <= '0;
      results.valid <= 1'b0;
    end else begin
      if (fire) begin
        results.valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      if (pop) begin
        started <= 1'b1;
        fin     <= op.last;
        pend_v  <= op.glyph;
        if (op.cp_newline) begin
          height <= h_sum[H_W] ? H_LIMIT : h_sum[H_W-1:0];
          max_x  <= widest(max_x, x1);
          cur_x  <= '0;
          sat    <= sat | ovf1 | h_sum[H_W];
        end else begin
          height <= h_base;
          cur_x  <= x1;
          sat    <= sat | ovf1;
        end
      end
      if (fire) begin
        results.text_width  <= widest(max_x, x2);
        results.text_height <= height;
        results.saturated   <= sat | ovf2;
        started             <= 1'b0;
        sat                 <= 1'b0;
        pend_v              <= 1'b0;
        fin                 <= 1'b0;
        cur_x               <= '0;
        max_x               <= '0;
        height              <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pend_adv  <= op.advance;
      pend_trim <= op.trim;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tem_checker.sv =====
// ----------------------------------------------------------------------------
// Text extent port checker
// Checks reset behaviour and result stability on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module tem_checker import tem_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              items_ready,
  input wire logic              results_valid,
  input wire logic              results_ready,
  input wire logic [MAXX_W-1:0] text_width,
  input wire logic [H_W-1:0]    text_height,
  input wire logic              saturated
);

  // The glyph table is swept after reset, so no item may be taken at once.
  a_ready_low_after_reset: assert property (@(posedge clk) rst |=> !items_ready)
    else $error("item channel ready directly after reset");

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !results_valid)
    else $error("result offered directly after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    results_valid && !results_ready |=>
      results_valid && $stable(text_width) && $stable(text_height) && $stable(saturated))
    else $error("stalled result transaction changed");

endmodule

bind text_extent_measure tem_checker u_tem_checker (
  .clk           (clk),
  .rst           (rst),
  .items_ready   (items.ready),
  .results_valid (results.valid),
  .results_ready (results.ready),
  .text_width    (results.text_width),
  .text_height   (results.text_height),
  .saturated     (results.saturated)
);

`default_nettype wire

// ===== test/tem_extent_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text extent checker
// Watches the item, result and configuration ports of the text extent block.
// It keeps its own copy of the glyph table, the registers and the per-string
// decoding state, works out the extent of every string that ends, and
// compares each result transaction with the oldest extent still outstanding.
// ----------------------------------------------------------------------------

module tem_extent_checker import tem_pkg::*; #(
  parameter int unsigned GLYPHS = GLYPHS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  tem_item_if               items,
  tem_result_if             results,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFGD_W-1:0] cfg_data,
  output int                fail_count,
  output int                awaiting,
  output int                checked
);

  localparam int X_HI = 8388607;
  localparam int X_LO = -8388608;
  localparam int H_HI = 16777215;

  typedef struct packed {
    logic [MAXX_W-1:0] width;
    logic [H_W-1:0]    height;
    logic              sat;
  } extent_t;

  extent_t expected_extents[$];

  bit glyph_on   [GLYPHS];
  int glyph_adv  [GLYPHS];
  int glyph_trim [GLYPHS];

  logic [LH_W-1:0]   line_h;
  bit                esc_on;
  logic [CODE_W-1:0] esc_cp;
  bit                trim_on;

  logic [CODE_W-1:0] cp_acc;
  int                cont_left;
  int                skip_count;
  bit                held;
  int                held_adv;
  int                held_trim;
  int                line_x;
  int                widest;
  int                height_sum;
  bit                begun;
  bit                clamped;

  function automatic void log_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("Error: %s", what);
  endfunction

  function automatic void clear_string();
    cp_acc     = '0;
    cont_left  = 0;
    skip_count = 0;
    held       = 1'b0;
    held_adv   = 0;
    held_trim  = 0;
    line_x     = 0;
    widest     = 0;
    height_sum = 0;
    begun      = 1'b0;
    clamped    = 1'b0;
  endfunction

  function automatic void shift_x(int delta);
    int s;
    s = line_x + delta;
    if (s > X_HI) begin
      s = X_HI;
      clamped = 1'b1;
    end
    if (s < X_LO) begin
      s = X_LO;
      clamped = 1'b1;
    end
    line_x = s;
  endfunction

  function automatic void take_code(logic [CODE_W-1:0] cp, bit fin);
    if (skip_count > 0) begin
      skip_count--;
      return;
    end
    if (cp == NEWLINE_CODE) begin
      height_sum = height_sum + int'(line_h);
      if (height_sum > H_HI) begin
        height_sum = H_HI;
        clamped = 1'b1;
      end
      if (line_x > widest) widest = line_x;
      line_x = 0;
      return;
    end
    if (esc_on && cp == esc_cp) begin
      skip_count = 3;
      return;
    end
    if (cp >= GLYPHS) return;
    if (!glyph_on[cp]) return;
    if (fin) begin
      shift_x(trim_on ? glyph_trim[cp] : glyph_adv[cp]);
    end else begin
      held      = 1'b1;
      held_adv  = glyph_adv[cp];
      held_trim = glyph_trim[cp];
    end
  endfunction

  function automatic void measure_byte(logic [BYTE_W-1:0] b, bit fin);
    if (!begun) begin
      begun = 1'b1;
      height_sum = int'(line_h);
    end
    if (held) begin
      held = 1'b0;
      shift_x((trim_on && b == NEWLINE_BYTE) ? held_trim : held_adv);
    end
    if (cont_left > 0) begin
      cp_acc = {cp_acc[CODE_W-7:0], b[5:0]};
      cont_left--;
      if (cont_left == 0) take_code(cp_acc, fin);
    end else if (!b[7]) begin
      take_code(CODE_W'(b), fin);
    end else if (b[7:5] == 3'b110) begin
      cp_acc = CODE_W'(b[4:0]);
      cont_left = 1;
    end else if (b[7:4] == 4'b1110) begin
      cp_acc = CODE_W'(b[3:0]);
      cont_left = 2;
    end else begin
      cp_acc = CODE_W'(b[2:0]);
      cont_left = 3;
    end
    if (fin) begin
      if (line_x > widest) widest = line_x;
      expected_extents.insert(expected_extents.size(),
                              extent_t'{width:  widest[MAXX_W-1:0],
                                        height: height_sum[H_W-1:0],
                                        sat:    clamped});
      clear_string();
    end
  endfunction

  always @(posedge clk) begin
    extent_t want;
    if (rst) begin
      foreach (glyph_on[i]) begin
        glyph_on[i]   = 1'b0;
        glyph_adv[i]  = 0;
        glyph_trim[i] = 0;
      end
      line_h  = LINE_HEIGHT_RESET;
      esc_on  = ESCAPE_ENABLE_RESET;
      esc_cp  = ESCAPE_CODE_RESET;
      trim_on = TRIM_LAST_RESET;
      clear_string();
      expected_extents.delete();
    end else begin
      if (results.valid && results.ready) begin
        checked++;
        if (expected_extents.size() == 0) begin
          log_failure($sformatf("unexpected result width %0d height %0d saturated %0b",
                                results.text_width, results.text_height, results.saturated));
        end else begin
          want = expected_extents.pop_front();
          if (results.text_width !== want.width || results.text_height !== want.height ||
              results.saturated !== want.sat) begin
            log_failure($sformatf({"result %0d: expected width %0d height %0d saturated %0b,",
                                   " got width %0d height %0d saturated %0b"},
                                  checked, want.width, want.height, want.sat,
                                  results.text_width, results.text_height,
                                  results.saturated));
          end
        end
      end
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_LINE_HEIGHT:   line_h  = cfg_data[LH_W-1:0];
          REG_ESCAPE_ENABLE: esc_on  = cfg_data[0];
          REG_ESCAPE_CODE:   esc_cp  = cfg_data[CODE_W-1:0];
          REG_TRIM_LAST:     trim_on = cfg_data[0];
          default: ;
        endcase
      end
      if (items.valid && items.ready) begin
        if (items.kind) begin
          if (items.glyph_code < GLYPHS) begin
            glyph_on[items.glyph_code]   = items.glyph_present;
            glyph_adv[items.glyph_code]  = int'($signed(items.glyph_advance));
            glyph_trim[items.glyph_code] = int'($signed(items.glyph_xoffset)) +
                                           int'(items.glyph_width);
          end
        end else begin
          measure_byte(items.text_byte, items.last);
        end
      end
    end
    awaiting = expected_extents.size();
  end

endmodule

// ===== test/tb_text_extent_measure.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text extent measure testbench
// Loads glyph tables and sends UTF-8 strings through the item channel under
// a range of register settings and handshake idling, including overlong and
// truncated sequences, escapes, missing glyphs and a long receiver hold-off.
// A separate checker predicts and compares every result transaction.
// ----------------------------------------------------------------------------

module tb_text_extent_measure;
  import tem_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 140;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFGI_W-1:0] cfg_index;
  logic [CFGD_W-1:0] cfg_data;

  tem_item_if   item_ch ();
  tem_result_if result_ch ();

  int fail_count;
  int awaiting;
  int checked;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_len       = 0;
  int hold_token     = 0;
  int items_sent     = 0;
  int loads_sent     = 0;
  int strings_sent   = 0;
  int settings_used  = 1;

  logic [CODE_W-1:0] esc_code_now = ESCAPE_CODE_RESET;
  logic [BYTE_W-1:0] text_buf[$];

  text_extent_measure u_top (
    .clk       (clk),
    .rst       (rst),
    .items     (item_ch),
    .results   (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tem_extent_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .items      (item_ch),
    .results    (result_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .awaiting   (awaiting),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles", cycles);
    $display("Mismatches found");
    $finish;
  end

  initial begin : receiver
    int hold_cnt;
    int hold_seen;
    hold_cnt  = 0;
    hold_seen = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_cnt  = hold_len;
      end
      if (hold_cnt > 0) begin
        result_ch.ready <= 1'b0;
        hold_cnt--;
      end else begin
        result_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  task automatic offer(logic kind_v, logic [BYTE_W-1:0] byte_v, logic last_v,
                       logic [GCODE_W-1:0] code_v, logic pres_v, logic [ADV_W-1:0] adv_v,
                       logic [ADV_W-1:0] xoff_v, logic [GW_W-1:0] wid_v);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.kind          <= kind_v;
    item_ch.text_byte     <= byte_v;
    item_ch.last          <= last_v;
    item_ch.glyph_code    <= code_v;
    item_ch.glyph_present <= pres_v;
    item_ch.glyph_advance <= adv_v;
    item_ch.glyph_xoffset <= xoff_v;
    item_ch.glyph_width   <= wid_v;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_glyph(logic [GCODE_W-1:0] code, logic pres, logic [ADV_W-1:0] adv,
                            logic [ADV_W-1:0] xoff, logic [GW_W-1:0] wid);
    offer(1'b1, BYTE_W'($urandom), 1'($urandom), code, pres, adv, xoff, wid);
    loads_sent++;
  endtask

  task automatic random_glyph(logic [GCODE_W-1:0] code);
    load_glyph(code, $urandom_range(99, 0) < 85, ADV_W'($urandom), ADV_W'($urandom),
               GW_W'($urandom));
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] b, logic fin);
    offer(1'b0, b, fin, GCODE_W'($urandom), 1'($urandom), ADV_W'($urandom),
          ADV_W'($urandom), GW_W'($urandom));
  endtask

  task automatic send_text();
    int n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99, 0) < 3) random_glyph(GCODE_W'($urandom));
      send_byte(text_buf[i], i == n - 1);
    end
    text_buf.delete();
    strings_sent++;
  endtask

  function automatic int min_len(logic [CODE_W-1:0] cp);
    if (cp < 128) return 1;
    if (cp < 2048) return 2;
    if (cp < 65536) return 3;
    return 4;
  endfunction

  function automatic int pick_len(logic [CODE_W-1:0] cp);
    if ($urandom_range(3, 0) != 0) return min_len(cp);
    return $urandom_range(4, min_len(cp));
  endfunction

  function automatic void append_byte(logic [BYTE_W-1:0] v);
    text_buf.insert(text_buf.size(), v);
  endfunction

  // Continuation bytes carry random top bits, which the decoder ignores.
  function automatic void put_code(logic [CODE_W-1:0] cp, int len);
    case (len)
      1: append_byte({1'b0, cp[6:0]});
      2: begin
        append_byte({3'b110, cp[10:6]});
        append_byte({2'($urandom), cp[5:0]});
      end
      3: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte({2'($urandom), cp[11:6]});
        append_byte({2'($urandom), cp[5:0]});
      end
      default: begin
        case ($urandom_range(2, 0))
          0: append_byte({5'b11110, cp[20:18]});
          1: append_byte({5'b11111, cp[20:18]});
          default: append_byte({2'b10, 3'($urandom), cp[20:18]});
        endcase
        append_byte({2'($urandom), cp[17:12]});
        append_byte({2'($urandom), cp[11:6]});
        append_byte({2'($urandom), cp[5:0]});
      end
    endcase
  endfunction

  function automatic void build_text(int tokens);
    int r;
    int len;
    logic [CODE_W-1:0] cp;
    repeat (tokens) begin
      r = $urandom_range(99, 0);
      if (r < 45) begin
        if ($urandom_range(3, 0) != 0) cp = CODE_W'($urandom_range(127, 0));
        else cp = CODE_W'($urandom_range(GLYPHS_DEFAULT - 1, 0));
        put_code(cp, pick_len(cp));
      end else if (r < 57) begin
        put_code(NEWLINE_CODE, ($urandom_range(4, 0) == 0) ? $urandom_range(4, 2) : 1);
      end else if (r < 67) begin
        put_code(esc_code_now, min_len(esc_code_now));
      end else if (r < 75) begin
        cp = CODE_W'($urandom_range(2097151, GLYPHS_DEFAULT));
        put_code(cp, pick_len(cp));
      end else begin
        append_byte(BYTE_W'($urandom));
      end
    end
    if ($urandom_range(99, 0) < 8) begin
      len = $urandom_range(4, 2);
      put_code(CODE_W'($urandom), len);
      repeat ($urandom_range(len - 1, 1)) void'(text_buf.pop_back());
    end
  endfunction

  task automatic settle();
    item_ch.valid <= 1'b0;
    do @(negedge clk); while (awaiting != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(logic [LH_W-1:0] lh, logic en, logic [CODE_W-1:0] code,
                            logic trim);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_LINE_HEIGHT;
    cfg_data  <= {11'($urandom), lh};
    @(posedge clk);
    cfg_index <= REG_ESCAPE_ENABLE;
    cfg_data  <= {20'($urandom), en};
    @(posedge clk);
    cfg_index <= REG_ESCAPE_CODE;
    cfg_data  <= code;
    @(posedge clk);
    cfg_index <= REG_TRIM_LAST;
    cfg_data  <= {20'($urandom), trim};
    @(posedge clk);
    cfg_we <= 1'b0;
    esc_code_now = code;
    settings_used++;
  endtask

  task automatic random_phase(logic [LH_W-1:0] lh, logic en, logic [CODE_W-1:0] code,
                              logic trim, int idle, int stall, bit squeeze);
    int stop;
    set_config(lh, en, code, trim);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    if (squeeze) begin
      hold_len = 400;
      hold_token++;
      repeat (40) begin
        append_byte(BYTE_W'($urandom_range(127, 0)));
        send_text();
      end
    end
    stop = items_sent + PHASE_ITEMS;
    while (items_sent < stop) begin
      if ($urandom_range(99, 0) < 20) begin
        if ($urandom_range(1, 0) == 0) random_glyph(GCODE_W'($urandom_range(127, 0)));
        else random_glyph(GCODE_W'($urandom));
      end else begin
        build_text($urandom_range(10, 1));
        send_text();
      end
    end
  endtask

  initial begin : stimulus
    item_ch.valid         <= 1'b0;
    item_ch.kind          <= 1'b0;
    item_ch.text_byte     <= '0;
    item_ch.last          <= 1'b0;
    item_ch.glyph_code    <= '0;
    item_ch.glyph_present <= 1'b0;
    item_ch.glyph_advance <= '0;
    item_ch.glyph_xoffset <= '0;
    item_ch.glyph_width   <= '0;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_LINE_HEIGHT;
    cfg_data              <= '0;
    rst                   <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    load_glyph(10'd65, 1'b1, 10'h1FF, 10'h200, 10'h3FF);
    load_glyph(10'd0, 1'b1, 10'h200, 10'h1FF, 10'h000);
    load_glyph(10'd1023, 1'b1, 10'd7, 10'd1, 10'd5);
    load_glyph(10'd66, 1'b0, 10'h155, 10'h2AA, 10'h3FF);
    load_glyph(ESCAPE_CODE_RESET[GCODE_W-1:0], 1'b1, 10'd3, 10'd0, 10'd2);
    put_code(21'd65, 1);
    put_code(NEWLINE_CODE, 1);
    send_text();
    put_code(21'd65, 1);
    put_code(21'd66, 1);
    put_code(ESCAPE_CODE_RESET, 1);
    send_text();
    text_buf = '{8'hCF, 8'hBF, 8'hE0, 8'h80, 8'h80};
    send_text();
    text_buf = '{8'hF0, 8'h80, 8'h81, 8'h81, 8'hD0, 8'h80};
    send_text();
    text_buf = '{8'h41, 8'hE2};
    send_text();

    set_config(10'd1023, 1'b1, ESCAPE_CODE_RESET, 1'b0);
    put_code(ESCAPE_CODE_RESET, 1);
    put_code(NEWLINE_CODE, 1);
    put_code(21'd65, 1);
    put_code(21'd65, 1);
    put_code(NEWLINE_CODE, 1);
    send_text();
    put_code(21'd65, 1);
    put_code(21'd65, 1);
    send_text();

    for (int c = 0; c < 128; c++) random_glyph(GCODE_W'(c));

    random_phase(10'd16, 1'b0, 21'd94, 1'b1, 0, 0, 1'b0);
    random_phase(10'd0, 1'b1, 21'd94, 1'b0, 69, 0, 1'b0);
    random_phase(10'd1023, 1'b1, 21'd0, 1'b1, 0, 69, 1'b0);
    random_phase(10'd1, 1'b1, 21'd1114111, 1'b0, 23, 23, 1'b0);
    random_phase(10'd512, 1'b0, CODE_W'($urandom), 1'b1, 0, 0, 1'b1);
    random_phase(LH_W'($urandom), 1'b1, CODE_W'($urandom_range(1023, 0)), 1'b1, 69, 0, 1'b0);
    random_phase(LH_W'($urandom), 1'b1, CODE_W'($urandom_range(1114111, 0)), 1'b0,
                 0, 69, 1'b0);
    random_phase(LH_W'($urandom), 1'($urandom), CODE_W'($urandom_range(127, 0)),
                 1'($urandom), 23, 23, 1'b0);

    settle();
    $display("Sent %0d strings and %0d glyph loads in %0d transactions over %0d settings,",
             strings_sent, loads_sent, items_sent, settings_used);
    $display("with handshake idling, escapes, truncated sequences and a long result hold-off;"
             , " %0d results checked.", checked);
    if (fail_count == 0 && awaiting == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
